/* design/demand_capacitance_estimator_top_assert.svh */
// Assertion macros for the demand capacitance estimator.
`ifndef DEMAND_CAPACITANCE_ESTIMATOR_TOP_ASSERT_SVH
`define DEMAND_CAPACITANCE_ESTIMATOR_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define DCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define DCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dce_pkg.sv */
// Types and constants shared by the demand capacitance estimator modules.
package dce_pkg;

  typedef struct packed {
    logic signed [31:0] demand_flux;
    logic signed [31:0] supply_potential;
    logic        [30:0] time_step;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] effective_conductivity;
    logic signed [31:0] capacitance_estimate;
  } out_beat_t;

  typedef enum logic [1:0] {
    CFG_MIN_COND  = 2'd0,
    CFG_MIN_DELTA = 2'd1,
    CFG_GAIN      = 2'd2
  } cfg_idx_e;

  localparam logic [16:0] GAIN_ONE = 17'd65536;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] quotient;
  } div_resp_t;

endpackage

/* design/dce_divider.sv */
// Radix-2 restoring divider, 64 by 32 bits, one quotient bit per cycle, saturated result.
module dce_divider (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dce_pkg::div_req_t    req_i,
  output dce_pkg::div_resp_t   resp_o
);

  localparam int unsigned Steps = 32;
  localparam int unsigned CntW  = $clog2(Steps);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     rem_q, rem_d;
  logic [31:0]     quo_q, quo_d;
  logic [31:0]     den_q, den_d;
  logic            neg_q, neg_d;
  logic            ovf_q, ovf_d;

  logic [32:0]     rem_sh;
  logic [32:0]     rem_sub;
  logic            fits;

  always_comb begin
    rem_sh  = {rem_q, quo_q[31]};
    rem_sub = rem_sh - {1'b0, den_q};
    fits    = rem_sh >= {1'b0, den_q};

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    ovf_d  = ovf_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.dividend[63:32];
      quo_d  = req_i.dividend[31:0];
      den_d  = req_i.divisor;
      neg_d  = req_i.neg;
      ovf_d  = req_i.dividend[63:32] >= req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[31:0] : rem_sh[31:0];
      quo_d = {quo_q[30:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
    ovf_q <= ovf_d;
  end

  always_comb begin
    resp_o.busy = busy_q;
    resp_o.done = done_q;
    if (neg_q) begin
      if (ovf_q || (quo_q > 32'h8000_0000)) begin
        resp_o.quotient = 32'sh8000_0000;
      end else begin
        resp_o.quotient = $signed(32'd0 - quo_q);
      end
    end else begin
      if (ovf_q || quo_q[31]) begin
        resp_o.quotient = 32'sh7FFF_FFFF;
      end else begin
        resp_o.quotient = $signed(quo_q);
      end
    end
  end

endmodule

/* design/demand_capacitance_estimator_top.sv */
// Top level of the demand capacitance estimator: sequencer, shared multiplier and state.
//
//   channel | handshake              | beat
//   --------+------------------------+-------------------------------------------
//   in      | in_valid_i/in_ready_o   | demand_flux, supply_potential, time_step
//   out     | out_valid_o/out_ready_i | effective_conductivity, capacitance_estimate
//   cfg     | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// An update of the capacitance makes two passes through the 32-step radix-2 divider,
// a held capacitance makes one; a zero time step skips the conductivity division.
// One beat is in work at a time; in_ready_o is high only while the sequencer idles.
// The output register holds a finished result; the next beat is taken while it waits.
// Reset clears configuration, averages and the capacitance estimate to zero.
`include "demand_capacitance_estimator_top_assert.svh"

module demand_capacitance_estimator_top #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dce_pkg::in_beat_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dce_pkg::out_beat_t   out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [30:0]          cfg_wdata_i
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_AVG   = 11'b000_0000_0010,
    ST_CHK   = 11'b000_0000_0100,
    ST_MULQ  = 11'b000_0000_1000,
    ST_QGO   = 11'b000_0001_0000,
    ST_QWAIT = 11'b000_0010_0000,
    ST_MIX1  = 11'b000_0100_0000,
    ST_MIX2  = 11'b000_1000_0000,
    ST_MIX3  = 11'b001_0000_0000,
    ST_GGO   = 11'b010_0000_0000,
    ST_GWAIT = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [30:0]        min_cond_q;
  logic [30:0]        min_dp_q;
  logic [16:0]        gain_q;

  logic signed [31:0] avg_dem_q, avg_dem_d;
  logic signed [31:0] avg_sup_q, avg_sup_d;
  logic signed [31:0] cap_q, cap_d;

  logic signed [31:0] flux_q;
  logic signed [31:0] sup_q;
  logic [30:0]        dt_q;
  logic [32:0]        delta_q, delta_d;
  logic signed [64:0] prod_q, prod_d;
  logic signed [49:0] acc_q, acc_d;
  logic signed [31:0] qs_q, qs_d;
  logic signed [31:0] g_q, g_d;

  logic                out_valid_q, out_valid_d;
  dce_pkg::out_beat_t  out_q, out_d;

  logic [32:0]        sum_dem, rnd_dem;
  logic [32:0]        sum_sup, rnd_sup;
  logic [32:0]        delta_abs;
  logic [64:0]        prod_abs;
  logic [31:0]        cap_abs;
  logic [16:0]        gain_c;
  logic [16:0]        gain_inv;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;
  logic signed [49:0] mix_sum;
  logic signed [49:0] mix_rnd;
  logic signed [31:0] floor_g;

  dce_pkg::div_req_t  div_req;
  dce_pkg::div_resp_t div_resp;

  dce_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .resp_o (div_resp)
  );

  always_comb begin
    sum_dem   = {avg_dem_q[31], avg_dem_q} + {flux_q[31], flux_q};
    rnd_dem   = sum_dem + {32'd0, sum_dem[32]};
    sum_sup   = {avg_sup_q[31], avg_sup_q} + {sup_q[31], sup_q};
    rnd_sup   = sum_sup + {32'd0, sum_sup[32]};
    delta_abs = delta_q[32] ? (33'd0 - delta_q) : delta_q;
    prod_abs  = prod_q[64] ? (65'd0 - $unsigned(prod_q)) : $unsigned(prod_q);
    cap_abs   = cap_q[31] ? (32'd0 - $unsigned(cap_q)) : $unsigned(cap_q);
    gain_c    = (gain_q > dce_pkg::GAIN_ONE) ? dce_pkg::GAIN_ONE : gain_q;
    gain_inv  = dce_pkg::GAIN_ONE - gain_c;
    mix_sum   = acc_q + $signed(prod_q[49:0]);
    mix_rnd   = mix_sum + (mix_sum[49] ? 50'sd65535 : 50'sd0);
    floor_g   = $signed({1'b0, min_cond_q});
  end

  always_comb begin
    case (state_q)
      ST_MULQ: begin
        mul_a = $signed(33'd0 - {avg_dem_q[31], avg_dem_q});
        mul_b = $signed({1'b0, dt_q});
      end
      ST_MIX1: begin
        mul_a = $signed({16'd0, gain_inv});
        mul_b = cap_q;
      end
      ST_MIX2: begin
        mul_a = $signed({16'd0, gain_c});
        mul_b = qs_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    state_d     = state_q;
    avg_dem_d   = avg_dem_q;
    avg_sup_d   = avg_sup_q;
    cap_d       = cap_q;
    delta_d     = delta_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    qs_d        = qs_q;
    g_d         = g_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    div_req.start    = 1'b0;
    div_req.neg      = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_AVG;
        end
      end
      ST_AVG: begin
        avg_dem_d = $signed(rnd_dem[32:1]);
        avg_sup_d = $signed(rnd_sup[32:1]);
        delta_d   = {rnd_sup[32], rnd_sup[32:1]} - {avg_sup_q[31], avg_sup_q};
        state_d   = ST_CHK;
      end
      ST_CHK: begin
        state_d = (delta_abs > {2'b00, min_dp_q}) ? ST_MULQ : ST_GGO;
      end
      ST_MULQ: begin
        prod_d  = mul_p;
        state_d = ST_QGO;
      end
      ST_QGO: begin
        div_req.start    = 1'b1;
        div_req.neg      = prod_q[64] ^ delta_q[32];
        div_req.dividend = prod_abs[63:0];
        div_req.divisor  = delta_abs[31:0];
        state_d          = ST_QWAIT;
      end
      ST_QWAIT: begin
        if (div_resp.done) begin
          qs_d    = div_resp.quotient;
          state_d = ST_MIX1;
        end
      end
      ST_MIX1: begin
        prod_d  = mul_p;
        state_d = ST_MIX2;
      end
      ST_MIX2: begin
        acc_d   = $signed(prod_q[49:0]);
        prod_d  = mul_p;
        state_d = ST_MIX3;
      end
      ST_MIX3: begin
        cap_d   = $signed(mix_rnd[47:16]);
        state_d = ST_GGO;
      end
      ST_GGO: begin
        if (dt_q == 31'd0) begin
          g_d     = floor_g;
          state_d = ST_IDLE;
        end else begin
          div_req.start    = 1'b1;
          div_req.neg      = cap_q[31];
          div_req.dividend = {32'd0, cap_abs} << FRACTION_BITS;
          div_req.divisor  = {1'b0, dt_q};
          state_d          = ST_GWAIT;
        end
      end
      ST_GWAIT: begin
        if (!div_resp.busy) begin
          g_d     = (div_resp.quotient < floor_g) ? floor_g : div_resp.quotient;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if ((state_q == ST_GGO && dt_q == 31'd0) ||
        (state_q == ST_GWAIT && !div_resp.busy)) begin
      state_d = (out_valid_q && !out_ready_i) ? state_q : ST_IDLE;
      if (!(out_valid_q && !out_ready_i)) begin
        out_d.effective_conductivity = g_d;
        out_d.capacitance_estimate   = cap_q;
        out_valid_d                  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      min_cond_q  <= '0;
      min_dp_q    <= '0;
      gain_q      <= '0;
      avg_dem_q   <= '0;
      avg_sup_q   <= '0;
      cap_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      avg_dem_q   <= avg_dem_d;
      avg_sup_q   <= avg_sup_d;
      cap_q       <= cap_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          dce_pkg::CFG_MIN_COND:  min_cond_q <= cfg_wdata_i;
          dce_pkg::CFG_MIN_DELTA: min_dp_q   <= cfg_wdata_i;
          dce_pkg::CFG_GAIN:      gain_q     <= cfg_wdata_i[16:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      flux_q <= in_data_i.demand_flux;
      sup_q  <= in_data_i.supply_potential;
      dt_q   <= in_data_i.time_step;
    end
    delta_q <= delta_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    qs_q    <= qs_d;
    g_q     <= g_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DCE_ASSERT_IMP(a_div_start_idle, div_req.start, !div_resp.busy, "divider started while busy")
  `DCE_ASSERT_IMP(a_div_done_wait, div_resp.done,
                  (state_q == ST_QWAIT) || (state_q == ST_GWAIT), "divider result with no wait")
  `DCE_ASSERT_NXT(a_zero_dt_skip, (state_q == ST_GGO) && (dt_q == 31'd0), !div_resp.busy, "divider run on zero time step")
  `DCE_ASSERT_NXT(a_out_no_drop, out_valid_q && !out_ready_i, out_valid_q && $stable(out_q), "pending result overwritten")

endmodule

/* test/tb.sv */
// Testbench for demand_capacitance_estimator_top: directed table, then random beats.
`timescale 1ns / 100ps

module tb;

  localparam int          FRAC        = 16;
  localparam int          CYCLE_LIMIT = 500000;
  localparam logic [1:0]  CFG_UNUSED  = 2'd3;
  localparam longint      Q_MAX       = 64'sd2147483647;
  localparam longint      Q_MIN       = -64'sd2147483648;

  typedef struct packed {
    bit                 is_cfg;
    logic [1:0]         idx;
    logic [30:0]        wdata;
    dce_pkg::in_beat_t  beat;
    bit                 typed;
    dce_pkg::out_beat_t want;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  dce_pkg::in_beat_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  dce_pkg::out_beat_t out_data_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [30:0]        cfg_wdata_i;

  logic signed [31:0] demand_avg;
  logic signed [31:0] supply_avg;
  logic signed [31:0] cap_est;
  logic [30:0]        floor_cond;
  logic [30:0]        min_dp;
  logic [16:0]        cap_gain;
  logic signed [31:0] supply_walk;

  dce_pkg::out_beat_t pending_results [$];
  row_t               dir_rows [$];
  int                 mismatches = 0;
  int                 cycle_cnt = 0;
  logic               quiet_in;
  logic               quiet_out;
  logic               stalling;
  event               hold_go;

  demand_capacitance_estimator_top #(
    .FRACTION_BITS(FRAC)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] saturate_q16(longint v);
    if (v > Q_MAX) return 32'sh7FFF_FFFF;
    if (v < Q_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic dce_pkg::out_beat_t predict_conductivity(dce_pkg::in_beat_t b);
    longint             flux;
    longint             supply;
    longint             dt;
    longint             old_supply;
    longint             delta;
    longint             mag;
    longint             gain;
    longint             prod;
    longint             sample;
    longint             mix;
    longint             g;
    dce_pkg::out_beat_t r;
    flux       = longint'($signed(b.demand_flux));
    supply     = longint'($signed(b.supply_potential));
    dt         = longint'({33'd0, b.time_step});
    old_supply = longint'(supply_avg);
    demand_avg = saturate_q16((longint'(demand_avg) + flux) / 2);
    supply_avg = saturate_q16((old_supply + supply) / 2);
    delta      = longint'(supply_avg) - old_supply;
    mag        = (delta < 0) ? -delta : delta;
    if (mag > longint'({33'd0, min_dp})) begin
      gain    = (cap_gain > dce_pkg::GAIN_ONE) ? longint'({47'd0, dce_pkg::GAIN_ONE})
                                               : longint'({47'd0, cap_gain});
      prod    = -longint'(demand_avg) * dt;
      sample  = longint'(saturate_q16(prod / delta));
      mix     = (longint'({47'd0, dce_pkg::GAIN_ONE}) - gain) * longint'(cap_est) +
                gain * sample;
      cap_est = saturate_q16(mix / 65536);
    end
    if (dt > 0) begin
      g = longint'(saturate_q16((longint'(cap_est) * (64'sd1 <<< FRAC)) / dt));
      if (g < longint'({33'd0, floor_cond})) g = longint'({33'd0, floor_cond});
    end else begin
      g = longint'({33'd0, floor_cond});
    end
    r.effective_conductivity = g[31:0];
    r.capacitance_estimate   = cap_est;
    return r;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [30:0] d);
    case (idx)
      dce_pkg::CFG_MIN_COND:  floor_cond = d;
      dce_pkg::CFG_MIN_DELTA: min_dp     = d;
      dce_pkg::CFG_GAIN:      cap_gain   = d[16:0];
      default: ;
    endcase
  endfunction

  function automatic row_t beat_row(logic [31:0] f, logic [31:0] s, logic [30:0] t);
    row_t r;
    r = '0;
    r.beat.demand_flux      = f;
    r.beat.supply_potential = s;
    r.beat.time_step        = t;
    return r;
  endfunction

  function automatic row_t beat_row_exp(logic [31:0] f, logic [31:0] s, logic [30:0] t,
                                        logic [31:0] g, logic [31:0] c);
    row_t r;
    r = beat_row(f, s, t);
    r.typed = 1'b1;
    r.want.effective_conductivity = g;
    r.want.capacitance_estimate   = c;
    return r;
  endfunction

  function automatic row_t reg_row(logic [1:0] idx, logic [30:0] d);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.wdata  = d;
    return r;
  endfunction

  function automatic logic signed [31:0] small_signed(int bits);
    logic signed [31:0] v;
    v = $signed($urandom);
    return v >>> (31 - bits);
  endfunction

  function automatic logic signed [31:0] pick_edge();
    case ($urandom_range(4))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic dce_pkg::in_beat_t make_beat();
    dce_pkg::in_beat_t b;
    int                sel;
    sel = $urandom_range(99);
    if (sel < 65) begin
      b.demand_flux      = small_signed($urandom_range(26, 8));
      supply_walk        = saturate_q16(longint'(supply_walk) +
                                        longint'(small_signed($urandom_range(22, 4))));
      b.supply_potential = supply_walk;
      b.time_step        = ($urandom_range(9) == 0) ? 31'd0 : 31'($urandom_range(32'h40000, 1));
    end else if (sel < 82) begin
      b.demand_flux      = $urandom;
      b.supply_potential = $urandom;
      b.time_step        = 31'($urandom);
    end else begin
      b.demand_flux      = pick_edge();
      b.supply_potential = pick_edge();
      case ($urandom_range(3))
        0: b.time_step = 31'd0;
        1: b.time_step = 31'd1;
        2: b.time_step = '1;
        default: b.time_step = 31'($urandom);
      endcase
    end
    return b;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [30:0] d);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, d);
  endtask

  task automatic send_beat(dce_pkg::in_beat_t b, bit typed, dce_pkg::out_beat_t typed_want);
    dce_pkg::out_beat_t p;
    if (!quiet_in && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(30, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    p = predict_conductivity(b);
    pending_results.push_back(typed ? typed_want : p);
  endtask

  task automatic check_beat(dce_pkg::out_beat_t got);
    dce_pkg::out_beat_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
      return;
    end
    want = pending_results.pop_front();
    if (got.effective_conductivity !== want.effective_conductivity) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: effective_conductivity expected %0d actual %0d", $time,
                 want.effective_conductivity, got.effective_conductivity);
    end
    if (got.capacitance_estimate !== want.capacitance_estimate) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: capacitance_estimate expected %0d actual %0d", $time,
                 want.capacitance_estimate, got.capacitance_estimate);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_beat(out_data_o);
    if (stalling) begin
      out_ready_i <= 1'b0;
    end else if (quiet_out) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 8);
    end
  end

  initial begin
    stalling <= 1'b0;
    forever begin
      @(hold_go);
      stalling <= 1'b1;
      repeat (600) @(posedge clk_i);
      stalling <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= '0;
    cfg_wdata_i <= '0;
    quiet_in    <= 1'b0;
    quiet_out   <= 1'b0;
    demand_avg  = '0;
    supply_avg  = '0;
    cap_est     = '0;
    floor_cond  = '0;
    min_dp      = '0;
    cap_gain    = '0;
    supply_walk = '0;

    dir_rows = {
      beat_row_exp(32'h0000_0000, 32'h0000_0000, 31'h0, 32'h0, 32'h0),
      beat_row_exp(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h0, 32'h0),
      beat_row_exp(32'h8000_0000, 32'h8000_0000, 31'h0, 32'h0, 32'h0),
      reg_row(dce_pkg::CFG_GAIN, 31'(dce_pkg::GAIN_ONE)),
      beat_row(32'h8000_0000, 32'h7FFF_FFFF, 31'h0000_0001),
      beat_row(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF),
      beat_row(32'h0010_0000, 32'h0001_0000, 31'h0001_0000),
      beat_row(32'hFFFF_FFFF, 32'h0000_0001, 31'h0001_0000),
      beat_row(32'h0000_0001, 32'hFFFF_FFFF, 31'h0000_0001),
      reg_row(dce_pkg::CFG_MIN_DELTA, 31'h7FFF_FFFF),
      beat_row(32'h7FFF_FFFF, 32'h8000_0000, 31'h0001_0000),
      beat_row(32'h8000_0000, 32'h7FFF_FFFF, 31'h0000_0001),
      reg_row(dce_pkg::CFG_MIN_DELTA, 31'h0001_0000),
      beat_row(32'h0001_0000, 32'h0003_0000, 31'h0000_8000),
      beat_row(32'hFFFE_0000, 32'hFFFC_0000, 31'h0001_0000),
      beat_row(32'hFFFE_0000, 32'hFFFC_8000, 31'h0001_0000),
      reg_row(dce_pkg::CFG_MIN_COND, 31'h7FFF_FFFF),
      beat_row(32'h0002_0000, 32'h0000_0000, 31'h0),
      beat_row(32'h0002_0000, 32'h0004_0000, 31'h0001_0000),
      reg_row(dce_pkg::CFG_MIN_COND, 31'h0002_0000),
      reg_row(dce_pkg::CFG_GAIN, 31'h0001_FFFF),
      beat_row(32'h0005_0000, 32'hFFFF_0000, 31'h0000_4000),
      beat_row(32'hFFFB_0000, 32'h0002_0000, 31'h0002_0000),
      reg_row(CFG_UNUSED, 31'h7FFF_FFFF),
      beat_row(32'h0003_0000, 32'h0001_0000, 31'h0001_0000),
      reg_row(dce_pkg::CFG_GAIN, 31'h4000_8000),
      beat_row(32'h0001_8000, 32'h0000_8000, 31'h0000_2000),
      beat_row(32'h0000_0000, 32'h0000_0000, 31'h0),
      beat_row(32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].wdata);
      end else begin
        send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(dce_pkg::CFG_MIN_COND, 31'h0);
          write_reg(dce_pkg::CFG_MIN_DELTA, 31'h0);
          write_reg(dce_pkg::CFG_GAIN, 31'(dce_pkg::GAIN_ONE));
        end
        1: begin
          write_reg(dce_pkg::CFG_MIN_COND, 31'($urandom_range(32'h40000)));
          write_reg(dce_pkg::CFG_MIN_DELTA, 31'h100);
          write_reg(dce_pkg::CFG_GAIN, 31'($urandom_range(65535, 1)));
        end
        2: begin
          write_reg(dce_pkg::CFG_MIN_COND, 31'h7FFF_FFFF);
          write_reg(dce_pkg::CFG_MIN_DELTA, 31'h0);
          write_reg(dce_pkg::CFG_GAIN, 31'(dce_pkg::GAIN_ONE));
        end
        3: begin
          write_reg(dce_pkg::CFG_MIN_COND, 31'h0);
          write_reg(dce_pkg::CFG_MIN_DELTA, 31'h7FFF_FFFF);
          write_reg(dce_pkg::CFG_GAIN, 31'($urandom_range(65536)));
        end
        4: begin
          write_reg(dce_pkg::CFG_MIN_COND, 31'($urandom));
          write_reg(dce_pkg::CFG_MIN_DELTA, 31'($urandom_range(32'h10000)));
          write_reg(dce_pkg::CFG_GAIN, 31'h0001_FFFF);
        end
        5: begin
          write_reg(dce_pkg::CFG_MIN_COND, 31'($urandom_range(32'h1000)));
          write_reg(dce_pkg::CFG_MIN_DELTA, 31'($urandom));
          write_reg(dce_pkg::CFG_GAIN, 31'($urandom_range(32'h1FFFF)));
        end
        default: begin
          write_reg(dce_pkg::CFG_MIN_COND, 31'h0);
          write_reg(dce_pkg::CFG_MIN_DELTA, 31'h10);
          write_reg(dce_pkg::CFG_GAIN, 31'h0);
        end
      endcase
      quiet_in  <= (ph == 0);
      quiet_out <= (ph == 0);
      for (int n = 0; n < 100; n++) begin
        if (ph == 2 && n == 10) -> hold_go;
        if (ph == 4 && n == 50) begin
          in_valid_i <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        send_beat(make_beat(), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
